/* rtl/spi_rfc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SPI read frame checker package
// Shared widths, frame layout defaults, status codes and CRC constants.
// ----------------------------------------------------------------------------
package spi_rfc_pkg;

    localparam int POS_W  = 17;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int CRC_W  = 16;

    localparam int HEADER_BYTES_DEF = 4;
    localparam int DUMMY_BYTES_DEF  = 3;

    localparam logic [POS_W-1:0]  STATUS_BYTE_POS = POS_W'(3);
    localparam logic [CRC_W-1:0]  CRC_INIT        = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY_REFL   = 16'h8408;
    localparam logic [BYTE_W-1:0] MASK_RESET      = 8'hA0;

    typedef logic [1:0] frame_status_t;

    localparam frame_status_t STATUS_OK      = 2'd0;
    localparam frame_status_t STATUS_DEV_ERR = 2'd1;
    localparam frame_status_t STATUS_CRC_ERR = 2'd2;

endpackage
`default_nettype wire

/* rtl/spi_rfc_crc_byte.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SPI read frame checker: CRC byte update
// Advances a reflected CRC-16/CCITT by one byte in combinational logic.
// ----------------------------------------------------------------------------
module spi_rfc_crc_byte
    import spi_rfc_pkg::*;
(
    input  wire logic [CRC_W-1:0]  crc_in,
    input  wire logic [BYTE_W-1:0] data_in,
    output logic      [CRC_W-1:0]  crc_out
);

    always_comb
    begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data_in};
        // Eight shift steps, least significant bit first.
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule
`default_nettype wire

/* rtl/spi_read_frame_checker_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SPI read frame checker core
// Walks one received SPI read frame byte by byte, checks the device status
// byte and the payload CRC, and echoes every byte with its classification.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the input channel (in_valid/in_ready) together with the
// payload length of the frame they belong to. Each accepted word yields
// exactly one result word on the output channel (out_valid/out_ready).
// A frame is HEADER_BYTES header bytes, DUMMY_BYTES dummy bytes, the
// payload and a two-byte CRC sent low byte first. Payload bytes are flagged
// with payload_valid; the final CRC byte carries frame_last and the frame
// status (device error takes precedence over a CRC mismatch).
// Each accepted word goes to the result register. One word is taken
// every cycle unless the receiver stalls: the CRC update of a byte is
// combinational, so the frame state is ready for the next byte immediately.
// When the receiver stalls, the result is held in the output register and
// the input is taken only while that register is empty or being emptied.
// Reset returns the block to the start of a frame, sets the CRC to all
// ones, clears the device error flag and loads status_mask with 0xA0.
// Users write the status mask (cfg_we/cfg_wdata) only while idle; unchecked.
// ----------------------------------------------------------------------------
module spi_read_frame_checker_core
    import spi_rfc_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int DUMMY_BYTES  = DUMMY_BYTES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_we,
    input  wire logic [BYTE_W-1:0]   cfg_wdata,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [BYTE_W-1:0]   rx_byte,
    input  wire logic [LEN_W-1:0]    payload_len,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [BYTE_W-1:0]   out_byte,
    output logic                     payload_valid,
    output logic                     frame_last,
    output frame_status_t            frame_status
);

    // First payload byte position within the frame.
    localparam logic [POS_W-1:0] DATA_START = POS_W'(HEADER_BYTES + DUMMY_BYTES);

    // Frame state.
    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic [CRC_W-1:0]  crc_reg,      crc_next;
    logic              dev_err_reg,  dev_err_next;
    logic [BYTE_W-1:0] crc_lo_reg,   crc_lo_next;
    logic [BYTE_W-1:0] mask_reg;

    // Result register.
    logic              out_valid_reg,  out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              pay_valid_reg;
    logic              last_reg;
    frame_status_t     status_reg;

    logic              accept;
    logic [POS_W-1:0]  crc_lo_pos;
    logic [POS_W-1:0]  crc_hi_pos;
    logic              is_last;
    logic              is_payload;
    logic              is_crc_lo;
    logic [CRC_W-1:0]  crc_upd;
    logic [CRC_W-1:0]  crc_rx;
    frame_status_t     status_calc;

    // The output register frees up in the same cycle as it is read.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Byte classification against the length of the current word.
    assign crc_lo_pos = DATA_START + {{(POS_W-LEN_W){1'b0}}, payload_len};
    assign crc_hi_pos = crc_lo_pos + POS_W'(1);
    assign is_last    = pos_reg >= crc_hi_pos;
    assign is_payload = !is_last && (pos_reg >= DATA_START) && (pos_reg < crc_lo_pos);
    assign is_crc_lo  = !is_last && (pos_reg == crc_lo_pos);
    assign crc_rx     = {rx_byte, crc_lo_reg};

    spi_rfc_crc_byte u_crc
    (
        .crc_in  (crc_reg),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    // The device error outranks a CRC mismatch.
    always_comb
    begin
        priority if (dev_err_reg)
        begin
            status_calc = STATUS_DEV_ERR;
        end
        else if (crc_rx != crc_reg)
        begin
            status_calc = STATUS_CRC_ERR;
        end
        else
        begin
            status_calc = STATUS_OK;
        end
    end

    // Frame state update on each accepted word.
    always_comb
    begin
        pos_next     = pos_reg;
        crc_next     = crc_reg;
        dev_err_next = dev_err_reg;
        crc_lo_next  = crc_lo_reg;
        if (accept)
        begin
            if (is_last)
            begin
                // Closing a frame: the held CRC low byte is kept.
                pos_next     = '0;
                crc_next     = CRC_INIT;
                dev_err_next = 1'b0;
            end
            else
            begin
                if ((pos_reg == STATUS_BYTE_POS) && ((rx_byte & mask_reg) != '0))
                begin
                    dev_err_next = 1'b1;
                end
                if (is_payload)
                begin
                    crc_next = crc_upd;
                end
                if (is_crc_lo)
                begin
                    crc_lo_next = rx_byte;
                end
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            crc_reg       <= CRC_INIT;
            dev_err_reg   <= 1'b0;
            crc_lo_reg    <= '0;
            mask_reg      <= MASK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            dev_err_reg   <= dev_err_next;
            crc_lo_reg    <= crc_lo_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
        end
    end

    // Result payload, loaded on acceptance only.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg  <= rx_byte;
            pay_valid_reg <= is_payload;
            last_reg      <= is_last;
            status_reg    <= is_last ? status_calc : STATUS_OK;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign payload_valid = pay_valid_reg;
    assign frame_last    = last_reg;
    assign frame_status  = status_reg;

`ifndef NO_ASSERTIONS
    // While a closing word is shown, the frame state has been restarted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |->
            (pos_reg == '0 && crc_reg == CRC_INIT && !dev_err_reg))
        else $error("frame state not restarted after closing word");

    // A payload byte is never the closing byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(pay_valid_reg && last_reg))
        else $error("payload word marked as frame last");

    // Status is only reported on the closing byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (status_reg == STATUS_OK))
        else $error("status reported on a word that is not last");

    // A masked status bit on the status byte marks the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_last && pos_reg == STATUS_BYTE_POS
            && ((rx_byte & mask_reg) != '0)) |=> dev_err_reg)
        else $error("device error not recorded");
`endif

endmodule
`default_nettype wire
